// ===== hw/rtl/tkwt_pkg.sv =====
package tkwt_pkg;

   // slot count and stored weight width
   localparam int MAX_SLOTS     = 16;
   localparam int WEIGHT_BITS   = 32;
   localparam int ID_BITS       = 32;
   localparam int K_BITS        = 5;
   localparam int SLOT_IDX_BITS = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_BITS      = $clog2(MAX_SLOTS + 1);

   localparam logic [K_BITS-1:0] K_RESET = 5'd16;

   typedef logic [ID_BITS-1:0]     id_type;
   typedef logic [WEIGHT_BITS-1:0] weight_type;

   typedef enum logic {
      KIND_OFFER = 1'b0,
      KIND_READ  = 1'b1
   } kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   // offer broadcast to every cell
   typedef struct packed {
      logic       en;
      id_type     id;
      weight_type weight;
   } offer_type;

   // one slot as seen by the readout sequencer
   typedef struct packed {
      logic       emit;
      logic       last;
      id_type     id;
      weight_type weight;
   } slot_rd_type;

endpackage

// ===== hw/rtl/top_k_weight_tracker.sv =====
// running top-k tracker: keeps the k heaviest offered items (k from the csr
// register, reset 16, values above 16 act as 16) in a row of 16 slot cells
// sorted by ascending weight, lightest in slot 0. an offer request (tuser 0)
// at least as heavy as slot 0 is inserted after every kept entry of equal or
// smaller weight, the lower entries move down one slot and the lightest is
// dropped, so on ties the newer item wins; lighter offers are ignored. all
// cells compare against the offer in parallel and shift in the same cycle,
// so offers are taken one per clock while rsp holds no stalled result and
// produce no result. with k at zero an offer is passed straight to rsp with
// tlast set. a readout request (tuser 1) walks slots k-1 down to 0, one
// result per clock through the output register while rsp is not stalled,
// stops at the first empty slot (id 0), sets tlast on the final result and
// leaves the slots unchanged; it takes no other request until it ends, and
// it gives no result when slot k-1 is empty.
// write k only while no request is in flight.
module top_k_weight_tracker import tkwt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [63:0]       req_tdata,   // [31:0] item_id, [63:32] weight
   input  logic              req_tuser,   // kind: 0 offer, 1 readout
   // result channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [63:0]       rsp_tdata,   // [31:0] out_id, [63:32] out_weight
   output logic              rsp_tlast,   // last
   // configuration: k_in_use
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [K_BITS-1:0] csr_data
);

   state_type           state_ff, state_in;
   logic [K_BITS-1:0]   k_ff;
   logic [CNT_BITS-1:0] cursor_ff, cursor_in;
   logic [CNT_BITS-1:0] k_eff;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   id_type              rsp_id_ff, rsp_id_in;
   weight_type          rsp_weight_ff, rsp_weight_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_load;

   logic                out_free;
   logic                req_accept;
   kind_type            req_kind;
   id_type              req_id;
   weight_type          req_weight;
   offer_type           offer;
   slot_rd_type         rd;
   logic [CNT_BITS-1:0] cursor_dec;

   assign req_kind   = kind_type'(req_tuser);
   assign req_id     = req_tdata[31:0];
   assign req_weight = WEIGHT_BITS'(req_tdata[63:32]);

   // clamp k to the slot count
   assign k_eff = (32'(k_ff) > 32'(MAX_SLOTS)) ? CNT_BITS'(MAX_SLOTS) : CNT_BITS'(k_ff);

   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) & out_free;
   assign req_accept = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   assign offer.en     = req_accept & (req_kind == KIND_OFFER) & (k_eff != '0);
   assign offer.id     = req_id;
   assign offer.weight = req_weight;

   assign cursor_dec = cursor_ff - 1'b1;

   tkwt_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .offer    (offer),
      .k_eff    (k_eff),
      .rd_index (cursor_dec[SLOT_IDX_BITS-1:0]),
      .rd       (rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= K_RESET;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid & csr_ready) begin
            k_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_id_ff     <= rsp_id_in;
         rsp_weight_ff <= rsp_weight_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      rsp_load      = 1'b0;
      rsp_id_in     = rd.id;
      rsp_weight_in = rd.weight;
      rsp_last_in   = rd.last;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_kind == KIND_READ) begin
                  // start the walk at slot k-1
                  state_in  = ST_READ;
                  cursor_in = k_eff;
               end else if (k_eff == '0) begin
                  // pass-through
                  rsp_load      = 1'b1;
                  rsp_id_in     = req_id;
                  rsp_weight_in = req_weight;
                  rsp_last_in   = 1'b1;
               end
            end
         end
         ST_READ: begin
            if ((cursor_ff == '0) || !rd.emit) begin
               // top slot empty: nothing to emit
               state_in  = ST_IDLE;
               cursor_in = '0;
            end else if (out_free) begin
               rsp_load  = 1'b1;
               cursor_in = cursor_dec;
               if (rd.last) begin
                  state_in  = ST_IDLE;
                  cursor_in = '0;
               end
            end
         end
         default: begin
            state_in  = ST_IDLE;
            cursor_in = '0;
         end
      endcase

      rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_tready);
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {32'(rsp_weight_ff), rsp_id_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hw/rtl/tkwt_cell.sv =====
module tkwt_cell import tkwt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  offer_type  offer,
   input  logic       in_use,      // slot index below k
   input  logic       is_top,      // slot index is k-1
   input  logic       run_prev,    // all lower cells in use saw weight >= theirs
   input  logic       run_next,    // upper neighbor is taking part in the shift
   input  id_type     next_id,
   input  weight_type next_weight,
   input  logic       emit_above,
   output id_type     slot_id,
   output weight_type slot_weight,
   output logic       run,
   output logic       emit
);

   id_type     id_ff;
   weight_type weight_ff;

   assign run         = run_prev & in_use & (offer.weight >= weight_ff);
   assign emit        = in_use & (id_ff != '0) & (is_top | emit_above);
   assign slot_id     = id_ff;
   assign slot_weight = weight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff     <= '0;
         weight_ff <= '0;
      end else if (offer.en) begin
         if (run_next) begin
            // shift down: take the neighbor's entry
            id_ff     <= next_id;
            weight_ff <= next_weight;
         end else if (run) begin
            // insertion point
            id_ff     <= offer.id;
            weight_ff <= offer.weight;
         end
      end
   end

endmodule

// ===== hw/rtl/tkwt_chain.sv =====
module tkwt_chain import tkwt_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  offer_type                offer,
   input  logic [CNT_BITS-1:0]      k_eff,
   input  logic [SLOT_IDX_BITS-1:0] rd_index,
   output slot_rd_type              rd
);

   id_type               ids     [MAX_SLOTS];
   weight_type           weights [MAX_SLOTS];
   logic [MAX_SLOTS-1:0] run;
   logic [MAX_SLOTS-1:0] emit;
   logic [MAX_SLOTS-1:0] last;

   for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
      logic       run_prev;
      logic       run_next;
      logic       emit_above;
      id_type     next_id;
      weight_type next_weight;

      if (i == 0) begin : g_bottom
         assign run_prev = 1'b1;
         assign last[i]  = emit[i];
      end else begin : g_mid
         assign run_prev = run[i-1];
         assign last[i]  = emit[i] & ~emit[i-1];
      end

      if (i == MAX_SLOTS - 1) begin : g_top
         assign run_next    = 1'b0;
         assign emit_above  = 1'b0;
         assign next_id     = '0;
         assign next_weight = '0;
      end else begin : g_below
         assign run_next    = run[i+1];
         assign emit_above  = emit[i+1];
         assign next_id     = ids[i+1];
         assign next_weight = weights[i+1];
      end

      tkwt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .offer       (offer),
         .in_use      (CNT_BITS'(i) < k_eff),
         .is_top      (CNT_BITS'(i + 1) == k_eff),
         .run_prev    (run_prev),
         .run_next    (run_next),
         .next_id     (next_id),
         .next_weight (next_weight),
         .emit_above  (emit_above),
         .slot_id     (ids[i]),
         .slot_weight (weights[i]),
         .run         (run[i]),
         .emit        (emit[i])
      );
   end

   assign rd.emit   = emit[rd_index];
   assign rd.last   = last[rd_index];
   assign rd.id     = ids[rd_index];
   assign rd.weight = weights[rd_index];

endmodule

// ===== hw/rtl/tkwt_checker.sv =====
module tkwt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              req_tuser,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [63:0]       rsp_tdata,
   input logic              rsp_tlast
);

   // a result waiting for its consumer is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   // a readout request blocks new requests in the following cycle
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !req_tready)
      else $error("request taken right after a readout request");

   // while a readout run is unfinished no request is taken
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken in the middle of a readout run");

   // nothing is shown right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

endmodule

bind top_k_weight_tracker tkwt_checker u_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import tkwt_pkg::*;

   // run limits
   localparam int CLK_HALF     = 10;
   localparam int RESET_CYCLES = 6;
   localparam int SETTLE       = 20;      // idle margin after the last owed result
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PER_PHASE    = 45;

   // one result entry as it should appear on rsp
   typedef struct {
      id_type     id;
      weight_type weight;
      logic       last;
   } ranked_entry_type;

   // dut ports, inputs known from time zero
   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [63:0]       req_tdata  = '0;   // [31:0] item_id, [63:32] weight
   logic              req_tuser  = 1'b0; // kind
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [63:0]       rsp_tdata;         // [31:0] out_id, [63:32] out_weight
   logic              rsp_tlast;
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic [K_BITS-1:0] csr_data   = '0;

   // shadow of the slot row and the k register
   id_type            shadow_ids     [MAX_SLOTS];
   weight_type        shadow_weights [MAX_SLOTS];
   logic [K_BITS-1:0] shadow_k;

   // entries owed on rsp, oldest first
   ranked_entry_type pending_rsp [$];

   // bookkeeping
   int  error_count    = 0;
   int  offer_count    = 0;
   int  passthru_count = 0;
   int  readout_count  = 0;
   int  result_count   = 0;
   int  k_write_count  = 0;
   int  cycle_count    = 0;
   bit  quiet          = 1'b0;   // no idling on either side while set

   top_k_weight_tracker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // 20 ns clock
   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d entries still owed", cycle_count,
               pending_rsp.size());
      $display("testbench NOT OK");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------

   function automatic int active_slots();
      return (shadow_k > MAX_SLOTS) ? MAX_SLOTS : int'(shadow_k);
   endfunction

   // sorted insert: after every kept entry of equal or smaller weight,
   // lower entries move down and slot 0 falls off
   function automatic void insert_offer(id_type id, weight_type w, int k);
      int pos;
      int i;
      if (w < shadow_weights[0])
         return;   // lighter than everything kept
      pos = 1;
      while (pos < k && w >= shadow_weights[pos])
         pos++;
      pos--;
      for (i = 0; i < pos; i++) begin
         shadow_ids[i]     = shadow_ids[i + 1];
         shadow_weights[i] = shadow_weights[i + 1];
      end
      shadow_ids[pos]     = id;
      shadow_weights[pos] = w;
   endfunction

   // heaviest first, stop at the first empty slot
   function automatic void queue_readout(int k);
      int cursor;
      ranked_entry_type e;
      cursor = k;
      while (cursor > 0 && shadow_ids[cursor - 1] != '0) begin
         cursor--;
         e.id     = shadow_ids[cursor];
         e.weight = shadow_weights[cursor];
         e.last   = 1'b0;
         pending_rsp.push_back(e);
         result_count++;
      end
      if (cursor != k)
         pending_rsp[pending_rsp.size() - 1].last = 1'b1;
   endfunction

   function automatic void track_request(kind_type kind, id_type id, weight_type w);
      int k;
      ranked_entry_type e;
      k = active_slots();
      if (kind == KIND_READ) begin
         readout_count++;
         queue_readout(k);
      end else begin
         offer_count++;
         if (k == 0) begin
            // k of zero hands the offer straight back
            passthru_count++;
            result_count++;
            e.id     = id;
            e.weight = w;
            e.last   = 1'b1;
            pending_rsp.push_back(e);
         end else begin
            insert_offer(id, w, k);
         end
      end
   endfunction

   // ---------------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s at cycle %0d: got %h, wanted %h", what, cycle_count,
               got, want);
      error_count++;
   endtask

   function automatic int gap_len();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   // one process watches every handshake at the edge, so a request and a
   // result accepted at the same edge are handled in a fixed order
   initial begin : monitor
      int stall;
      ranked_entry_type want;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (csr_valid && csr_ready) begin
               shadow_k = csr_data;
               k_write_count++;
            end
            if (req_tvalid && req_tready)
               track_request(kind_type'(req_tuser), req_tdata[31:0], req_tdata[63:32]);
            if (rsp_tvalid && rsp_tready) begin
               if (pending_rsp.size() == 0) begin
                  // nothing owed, so any id is wrong
                  report_mismatch("unexpected out_id", rsp_tdata[31:0], 32'h0);
               end else begin
                  want = pending_rsp.pop_front();
                  if (rsp_tdata[31:0] !== want.id)
                     report_mismatch("out_id", rsp_tdata[31:0], want.id);
                  if (rsp_tdata[63:32] !== want.weight)
                     report_mismatch("out_weight", rsp_tdata[63:32], want.weight);
                  if (rsp_tlast !== want.last)
                     report_mismatch("last", 32'(rsp_tlast), 32'(want.last));
               end
            end
         end
         // receiver stalls
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            stall = gap_len();
            rsp_tready <= (stall == 0);
            if (stall > 0)
               stall--;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------------

   // one request; valid stays up into the next call when no gap is drawn
   task automatic send_request(kind_type kind, id_type id, weight_type w);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {w, id};
      do @(posedge clock); while (!req_tready);
   endtask

   // hold requests until every owed entry has come out
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // k is only written with the block idle
   task automatic write_k(logic [K_BITS-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic weight_type pick_weight();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return weight_type'($urandom_range(0, 15));   // many ties
         default: return weight_type'($urandom);
      endcase
   endfunction

   function automatic id_type pick_id();
      id_type id;
      if ($urandom_range(0, 49) == 0)
         return '0;   // stored, then reads as an empty slot
      id = $urandom;
      return (id == '0) ? id_type'(1) : id;
   endfunction

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // nothing kept yet, so a readout gives no result
   task automatic test_empty_readout();
      send_request(KIND_READ, '0, '0);
   endtask

   // sorted insert, ties, light offers and an id of zero, with k at 4
   task automatic test_ordering();
      quiet = 1'b1;
      write_k(5'd4);
      send_request(KIND_OFFER, 32'd10, 32'd5);
      send_request(KIND_OFFER, 32'd11, 32'd5);          // tie, newer sits higher
      send_request(KIND_OFFER, 32'd12, 32'hFFFF_FFFF);  // heaviest weight
      send_request(KIND_OFFER, 32'hFFFF_FFFF, 32'd7);   // largest id
      send_request(KIND_READ,  '1, '1);
      send_request(KIND_OFFER, 32'd13, 32'd1);          // lighter than slot 0
      send_request(KIND_OFFER, 32'd14, 32'd5);          // tie with slot 0, drops it
      send_request(KIND_READ,  '0, '0);
      send_request(KIND_OFFER, 32'd0, 32'd6);           // empty id cuts readouts short
      send_request(KIND_READ,  '0, '0);
      quiet = 1'b0;
   endtask

   // k of zero passes offers through and reads nothing
   task automatic test_passthrough();
      write_k(5'd0);
      send_request(KIND_OFFER, '1, '1);
      send_request(KIND_OFFER, 32'd1, '0);
      send_request(KIND_READ,  '0, '0);
   endtask

   // k above range, shrinking k and growing it back
   task automatic test_k_changes();
      write_k(5'd31);                                   // acts as 16
      send_request(KIND_READ,  '0, '0);
      send_request(KIND_OFFER, 32'd20, 32'd100);
      send_request(KIND_OFFER, 32'd21, 32'd200);
      send_request(KIND_READ,  '0, '0);
      write_k(5'd1);                                    // upper slots kept but hidden
      send_request(KIND_OFFER, 32'd22, 32'd50);
      send_request(KIND_READ,  '0, '0);
      write_k(5'd16);
      send_request(KIND_READ,  '0, '0);
   endtask

   // random offers and readouts over several k settings
   task automatic test_random_stream();
      logic [K_BITS-1:0] k_plan [7];
      int phase;
      int n;
      k_plan = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd8, 5'd0};
      k_plan[6] = K_BITS'($urandom_range(0, 31));
      for (phase = 0; phase < 7; phase++) begin
         quiet = (phase % 3 == 1);
         write_k(k_plan[phase]);
         for (n = 0; n < PER_PHASE; n++) begin
            // hold off once mid-stream until rsp has caught up
            if (phase == 3 && n == PER_PHASE / 2)
               drain_results();
            if ($urandom_range(0, 99) < 15)
               send_request(KIND_READ, $urandom, $urandom);
            else
               send_request(KIND_OFFER, pick_id(), pick_weight());
         end
      end
      quiet = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------

   initial begin : sequencer
      int i;
      // shadow reset state
      shadow_k = K_RESET;
      for (i = 0; i < MAX_SLOTS; i++) begin
         shadow_ids[i]     = '0;
         shadow_weights[i] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_readout();
      test_ordering();
      test_passthrough();
      test_k_changes();
      test_random_stream();
      drain_results();

      $display("covered %0d offers (%0d passed straight out) and %0d readouts",
               offer_count, passthru_count, readout_count);
      $display("%0d result entries compared across %0d k writes", result_count,
               k_write_count);
      if (error_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
